### src/car_pkg.sv
// Shared constants and types for the compartment access range recorder.
`default_nettype none

package car_pkg;

    // Table geometry.
    localparam int NUM_COMPARTMENTS       = 64;
    localparam int RANGES_PER_COMPARTMENT = 128;
    localparam int TABLE_DEPTH            = NUM_COMPARTMENTS * RANGES_PER_COMPARTMENT;

    // Index and counter widths, kept at least one bit wide.
    localparam int COMP_W   = (NUM_COMPARTMENTS > 1) ? $clog2(NUM_COMPARTMENTS) : 1;
    localparam int SLOT_W   = (RANGES_PER_COMPARTMENT > 1) ?
                              $clog2(RANGES_PER_COMPARTMENT) : 1;
    localparam int CNT_W    = $clog2(RANGES_PER_COMPARTMENT + 1);
    localparam int TABLE_AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    // Field widths of the stream payloads.
    localparam int OPCODE_W = 2;
    localparam int COMPID_W = 8;
    localparam int ADDR_W   = 32;
    localparam int INDEX_W  = 7;
    localparam int STATUS_W = 3;
    localparam int IN_W     = 88;
    localparam int OUT_W    = 104;
    localparam int OUT_PAD  = OUT_W - (STATUS_W + 3 * ADDR_W);

    // One word in bytes; ranges grow by this step.
    localparam logic [ADDR_W-1:0] WORD_BYTES = 32'd4;

    // Opcodes. Any opcode with the clear bit set clears the store.
    localparam logic [OPCODE_W-1:0] OP_RECORD    = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_READ      = 2'd1;
    localparam int                  OP_CLEAR_BIT = 1;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_NEW     = 3'd0,
        ST_START   = 3'd1,
        ST_END     = 3'd2,
        ST_COVERED = 3'd3,
        ST_BAD_ID  = 3'd4,
        ST_FULL    = 3'd5,
        ST_READ    = 3'd6,
        ST_CLEARED = 3'd7
    } status_t;

    // One range table entry.
    typedef struct packed {
        logic [ADDR_W-1:0] range_end;
        logic [ADDR_W-1:0] range_start;
    } range_t;

    // Per-compartment record: policy word and number of written slots.
    typedef struct packed {
        logic [ADDR_W-1:0] policy;
        logic [CNT_W-1:0]  count;
    } meta_t;

endpackage

`default_nettype wire

### src/compartment_access_range_recorder.sv
// Top level of the compartment access range recorder: sequencer, range table and policy table.
`default_nettype none

// A record transfer reads the compartment's policy record in S_META, then walks one slot of the
// range memory per cycle in S_WALK until a slot applies or the last slot is passed, then hands
// the result to the output register from S_DONE. A read goes through S_META, then S_READ if its
// index is in range, then S_DONE; a clear or a bad compartment id goes straight to S_DONE. The
// range table is a single-port-read, single-port-write memory walked one entry per cycle, which
// sets the record time. Each compartment keeps a count of the slots written since the last
// clear; slots at or above that count read as empty, so reset and the clear operation take
// effect at once with no sweep of the memory. The next input transfer is taken as soon as the
// sequencer is idle, even while a result waits.
module compartment_access_range_recorder
    import car_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    // opcode[1:0], comp_id[9:2], access_addr[41:10], policy_word[73:42],
    // entry_index[80:74], zero fill above
    input  wire logic [IN_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    // status[2:0], range_low[34:3], range_high[66:35], stored_policy[98:67],
    // zero fill above
    output logic [OUT_W-1:0]      m_tdata
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_META,
        S_WALK,
        S_READ,
        S_DONE
    } state_t;

    localparam logic [TABLE_AW-1:0] RPC_A     = TABLE_AW'(RANGES_PER_COMPARTMENT);
    localparam logic [SLOT_W-1:0]   SLOT_LAST = SLOT_W'(RANGES_PER_COMPARTMENT - 1);
    localparam logic [CNT_W-1:0]    CNT_MAX   = CNT_W'(RANGES_PER_COMPARTMENT);

    state_t                    state_reg;
    logic                      op_read_reg;
    logic [COMP_W-1:0]         comp_reg;
    logic [ADDR_W-1:0]         addr_reg;
    logic [ADDR_W-1:0]         pol_reg;
    logic [SLOT_W-1:0]         idx_reg;
    logic                      idx_ok_reg;
    logic [SLOT_W-1:0]         slot_reg;
    logic [CNT_W-1:0]          count_reg;
    logic [ADDR_W-1:0]         cur_pol_reg;
    status_t                   res_status_reg;
    logic [ADDR_W-1:0]         res_low_reg;
    logic [ADDR_W-1:0]         res_high_reg;
    logic [ADDR_W-1:0]         res_pol_reg;
    logic                      m_tvalid_reg;
    logic [OUT_W-1:0]          m_tdata_reg;
    logic [NUM_COMPARTMENTS-1:0] meta_vld_reg;

    // Memories and their ports.
    range_t                    range_mem [TABLE_DEPTH];
    meta_t                     meta_mem  [NUM_COMPARTMENTS];
    range_t                    rng_rd;
    meta_t                     meta_rd;
    logic [TABLE_AW-1:0]       rng_ra;
    logic [TABLE_AW-1:0]       rng_wa;
    logic [TABLE_AW-1:0]       rng_base;
    logic [SLOT_W-1:0]         rd_slot;
    logic                      rng_we;
    range_t                    rng_wd;
    logic                      meta_we;
    meta_t                     meta_wd;

    // Input fields.
    logic                      s_accept;
    logic [OPCODE_W-1:0]       in_opcode;
    logic [COMPID_W-1:0]       in_comp;
    logic [ADDR_W-1:0]         in_addr;
    logic [ADDR_W-1:0]         in_pol;
    logic [INDEX_W-1:0]        in_idx;
    logic                      in_comp_ok;
    logic                      in_idx_ok;

    // Policy record as seen after the read.
    logic                      meta_hit;
    logic [ADDR_W-1:0]         cur_pol;
    logic [CNT_W-1:0]          cur_cnt;

    // Slot evaluation during the walk.
    logic                      slot_vld;
    logic [ADDR_W-1:0]         cur_s;
    logic [ADDR_W-1:0]         cur_e;
    logic [ADDR_W-1:0]         below;
    logic [ADDR_W-1:0]         addr_inc;
    logic                      w_hit;
    status_t                   w_status;
    logic [ADDR_W-1:0]         w_start;
    logic [ADDR_W-1:0]         w_end;
    logic [CNT_W-1:0]          count_new;
    logic                      rd_vld;

    // Input unpacking and handshake.
    assign s_tready   = (state_reg == S_IDLE);
    assign s_accept   = s_tvalid && s_tready;
    assign in_opcode  = s_tdata[1:0];
    assign in_comp    = s_tdata[9:2];
    assign in_addr    = s_tdata[41:10];
    assign in_pol     = s_tdata[73:42];
    assign in_idx     = s_tdata[80:74];
    assign in_comp_ok = {1'b0, in_comp} < 9'(NUM_COMPARTMENTS);
    assign in_idx_ok  = {1'b0, in_idx} < 8'(RANGES_PER_COMPARTMENT);

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // A compartment that was never written since the last clear reads as all zero.
    assign meta_hit = meta_vld_reg[comp_reg];
    assign cur_pol  = meta_hit ? meta_rd.policy : '0;
    assign cur_cnt  = meta_hit ? meta_rd.count  : '0;

    // Range memory addressing: the walk prefetches the next slot every cycle.
    assign rng_base = TABLE_AW'(comp_reg) * RPC_A;
    always_comb begin
        case (state_reg)
            S_META:  rd_slot = op_read_reg ? idx_reg : '0;
            S_WALK:  rd_slot = slot_reg + SLOT_W'(1);
            default: rd_slot = '0;
        endcase
    end
    assign rng_ra = rng_base + TABLE_AW'(rd_slot);
    assign rng_wa = rng_base + TABLE_AW'(slot_reg);

    // Evaluate the slot whose data arrives this cycle.
    assign slot_vld = CNT_W'(slot_reg) < count_reg;
    assign cur_s    = slot_vld ? rng_rd.range_start : '0;
    assign cur_e    = slot_vld ? rng_rd.range_end   : '0;
    assign below    = cur_s - WORD_BYTES;
    assign addr_inc = addr_reg + WORD_BYTES;
    assign w_hit    = (cur_s == '0) || ((addr_reg >= below) && (addr_reg <= cur_e));

    always_comb begin
        if (cur_s == '0) begin
            w_status = ST_NEW;
            w_start  = addr_reg;
            w_end    = addr_inc;
        end else if (addr_reg == below) begin
            w_status = ST_START;
            w_start  = addr_reg;
            w_end    = cur_e;
        end else if (addr_reg == cur_e) begin
            w_status = ST_END;
            w_start  = cur_s;
            w_end    = addr_inc;
        end else begin
            w_status = ST_COVERED;
            w_start  = cur_s;
            w_end    = cur_e;
        end
    end

    // Writing the slot at the count extends the written prefix by one.
    assign count_new = (CNT_W'(slot_reg) == count_reg) ? count_reg + CNT_W'(1) : count_reg;

    assign rng_we              = (state_reg == S_WALK) && w_hit;
    assign rng_wd.range_start  = w_start;
    assign rng_wd.range_end    = w_end;
    assign meta_we             = rng_we;
    assign meta_wd.policy      = pol_reg;
    assign meta_wd.count       = count_new;

    // A read returns zeros for a slot that was not written since the last clear.
    assign rd_vld = CNT_W'(idx_reg) < count_reg;

    // Range table: one write and one registered read per cycle.
    always_ff @(posedge aclk) begin
        if (rng_we) begin
            range_mem[rng_wa] <= rng_wd;
        end
        rng_rd <= range_mem[rng_ra];
    end

    // Policy table: one write and one registered read per cycle.
    always_ff @(posedge aclk) begin
        if (meta_we) begin
            meta_mem[comp_reg] <= meta_wd;
        end
        meta_rd <= meta_mem[in_comp[COMP_W-1:0]];
    end

    // Sequencer and output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
            meta_vld_reg <= '0;
        end else begin
            // The output register empties on a transfer unless a new result loads it.
            if (m_tvalid_reg && m_tready && (state_reg != S_DONE)) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_accept) begin
                        op_read_reg <= (in_opcode == OP_READ);
                        comp_reg    <= in_comp[COMP_W-1:0];
                        addr_reg    <= in_addr;
                        pol_reg     <= in_pol;
                        idx_reg     <= in_idx[SLOT_W-1:0];
                        idx_ok_reg  <= in_idx_ok;
                        if (in_opcode[OP_CLEAR_BIT]) begin
                            meta_vld_reg   <= '0;
                            res_status_reg <= ST_CLEARED;
                            res_low_reg    <= '0;
                            res_high_reg   <= '0;
                            res_pol_reg    <= '0;
                            state_reg      <= S_DONE;
                        end else if (!in_comp_ok) begin
                            res_status_reg <= ST_BAD_ID;
                            res_low_reg    <= '0;
                            res_high_reg   <= '0;
                            res_pol_reg    <= '0;
                            state_reg      <= S_DONE;
                        end else begin
                            state_reg <= S_META;
                        end
                    end
                end
                S_META: begin
                    cur_pol_reg <= cur_pol;
                    count_reg   <= cur_cnt;
                    slot_reg    <= '0;
                    if (!op_read_reg) begin
                        state_reg <= S_WALK;
                    end else if (idx_ok_reg) begin
                        state_reg <= S_READ;
                    end else begin
                        res_status_reg <= ST_READ;
                        res_low_reg    <= '0;
                        res_high_reg   <= '0;
                        res_pol_reg    <= cur_pol;
                        state_reg      <= S_DONE;
                    end
                end
                S_READ: begin
                    res_status_reg <= ST_READ;
                    res_low_reg    <= rd_vld ? rng_rd.range_start : '0;
                    res_high_reg   <= rd_vld ? rng_rd.range_end   : '0;
                    res_pol_reg    <= cur_pol_reg;
                    state_reg      <= S_DONE;
                end
                S_WALK: begin
                    if (w_hit) begin
                        meta_vld_reg[comp_reg] <= 1'b1;
                        res_status_reg <= w_status;
                        res_low_reg    <= w_start;
                        res_high_reg   <= w_end;
                        res_pol_reg    <= pol_reg;
                        state_reg      <= S_DONE;
                    end else if (slot_reg == SLOT_LAST) begin
                        res_status_reg <= ST_FULL;
                        res_low_reg    <= '0;
                        res_high_reg   <= '0;
                        res_pol_reg    <= cur_pol_reg;
                        state_reg      <= S_DONE;
                    end else begin
                        slot_reg <= slot_reg + SLOT_W'(1);
                    end
                end
                S_DONE: begin
                    // Hand over once the output register is free or being emptied.
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {{OUT_PAD{1'b0}}, res_pol_reg, res_high_reg,
                                         res_low_reg, res_status_reg};
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // A clear leaves every compartment reading as empty on the next cycle.
    a_clear_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && in_opcode[OP_CLEAR_BIT]) |=> (meta_vld_reg == '0))
        else $error("clear did not empty the compartment table");

    // Range writes never skip past the written prefix of a compartment.
    a_write_in_prefix: assert property (@(posedge aclk) disable iff (!aresetn)
        rng_we |-> (CNT_W'(slot_reg) <= count_reg))
        else $error("range write beyond the written prefix");

    // The stored slot count stays within the table size.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        meta_we |-> (meta_wd.count <= CNT_MAX))
        else $error("slot count exceeds the table size");

    // A finished result waits while an earlier one is still held at the output.
    a_result_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE && m_tvalid_reg && !m_tready) |=> (state_reg == S_DONE))
        else $error("result overwrote a pending output transfer");

endmodule

`default_nettype wire

### verif/testbench.sv
// Self-checking testbench for the compartment access range recorder.
module testbench;
    import car_pkg::*;

    // Opcodes with the clear bit set; the block treats both alike.
    localparam logic [OPCODE_W-1:0] OP_CLEAR     = 2'b10;
    localparam logic [OPCODE_W-1:0] OP_CLEAR_ODD = 2'b11;

    // Address windows used to build ranges that touch each other.
    localparam logic [ADDR_W-1:0] REGION_A = 32'h1000_0000;
    localparam logic [ADDR_W-1:0] REGION_B = 32'h1000_E000;
    localparam int WINDOW_WORDS = 1024;

    localparam int ITEMS_PER_PHASE = 232;
    localparam int HOLDOFF_CYCLES  = 300;
    localparam int DRAIN_CYCLES    = 140;
    localparam int LIMIT_CYCLES    = 1_000_000;
    localparam int SHOWN_MISMATCHES = 10;

    // One input transfer, first field in the lowest bits.
    typedef struct packed {
        logic [INDEX_W-1:0]  entry_index;
        logic [ADDR_W-1:0]   policy_word;
        logic [ADDR_W-1:0]   access_addr;
        logic [COMPID_W-1:0] comp_id;
        logic [OPCODE_W-1:0] opcode;
    } access_req_t;

    // One result transfer, first field in the lowest bits.
    typedef struct packed {
        logic [ADDR_W-1:0] stored_policy;
        logic [ADDR_W-1:0] range_high;
        logic [ADDR_W-1:0] range_low;
        status_t           status;
    } access_rsp_t;

    // A directed stimulus row; the result is typed in only where typed is set.
    typedef struct packed {
        access_req_t req;
        bit          typed;
        access_rsp_t rsp;
    } directed_row_t;

    logic             aclk     = 1'b0;
    logic             aresetn  = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata  = '0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;

    // Shadow copy of the range store kept by the predictor.
    bit [ADDR_W-1:0] tbl_start  [TABLE_DEPTH];
    bit [ADDR_W-1:0] tbl_end    [TABLE_DEPTH];
    bit [ADDR_W-1:0] tbl_policy [NUM_COMPARTMENTS];

    access_rsp_t   pending_results [$];
    directed_row_t dir_rows [$];
    logic [COMPID_W-1:0] hot_comps [4];

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int ready_holdoff = 0;
    int cycle_count   = 0;
    int mismatch_count = 0;
    int results_checked = 0;
    int results_by_status [8];
    int n_records = 0;
    int n_reads   = 0;
    int n_bad_ids = 0;
    int n_clears  = 0;

    access_rsp_t mon_got;
    access_rsp_t mon_want;

    compartment_access_range_recorder dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #6 aclk = ~aclk;

    // Apply one request to the shadow store and return the result it causes.
    function automatic access_rsp_t range_table_apply(input access_req_t req);
        access_rsp_t       rsp;
        int unsigned       k;
        int unsigned       slot;
        logic [ADDR_W-1:0] lo;
        logic [ADDR_W-1:0] hi;
        logic [ADDR_W-1:0] below;
        bit                hit;
        rsp = '0;
        hit = 1'b0;
        if (req.opcode[OP_CLEAR_BIT]) begin
            for (k = 0; k < TABLE_DEPTH; k++) begin
                tbl_start[k] = '0;
                tbl_end[k]   = '0;
            end
            for (k = 0; k < NUM_COMPARTMENTS; k++)
                tbl_policy[k] = '0;
            rsp.status = ST_CLEARED;
        end else if (req.comp_id >= NUM_COMPARTMENTS) begin
            rsp.status = ST_BAD_ID;
        end else if (req.opcode == OP_READ) begin
            rsp.status = ST_READ;
            rsp.stored_policy = tbl_policy[req.comp_id];
            if (req.entry_index < RANGES_PER_COMPARTMENT) begin
                k = req.comp_id * RANGES_PER_COMPARTMENT + req.entry_index;
                rsp.range_low  = tbl_start[k];
                rsp.range_high = tbl_end[k];
            end
        end else begin
            // Walk the compartment's slots and stop at the first one that applies.
            for (slot = 0; slot < RANGES_PER_COMPARTMENT && !hit; slot++) begin
                k = req.comp_id * RANGES_PER_COMPARTMENT + slot;
                lo = tbl_start[k];
                hi = tbl_end[k];
                below = lo - WORD_BYTES;
                if (lo == '0) begin
                    tbl_start[k] = req.access_addr;
                    tbl_end[k]   = req.access_addr + WORD_BYTES;
                    rsp.status   = ST_NEW;
                    hit = 1'b1;
                end else if (req.access_addr >= below && req.access_addr <= hi) begin
                    hit = 1'b1;
                    if (req.access_addr == below) begin
                        tbl_start[k] = req.access_addr;
                        rsp.status   = ST_START;
                    end else if (req.access_addr == hi) begin
                        tbl_end[k] = req.access_addr + WORD_BYTES;
                        rsp.status = ST_END;
                    end else begin
                        rsp.status = ST_COVERED;
                    end
                end
                if (hit) begin
                    rsp.range_low  = tbl_start[k];
                    rsp.range_high = tbl_end[k];
                end
            end
            if (hit) begin
                tbl_policy[req.comp_id] = req.policy_word;
                rsp.stored_policy = req.policy_word;
            end else begin
                rsp.status = ST_FULL;
                rsp.stored_policy = tbl_policy[req.comp_id];
            end
        end
        return rsp;
    endfunction

    function automatic access_req_t make_req(input logic [OPCODE_W-1:0] op,
                                             input logic [COMPID_W-1:0] comp,
                                             input logic [ADDR_W-1:0] addr,
                                             input logic [ADDR_W-1:0] pol,
                                             input logic [INDEX_W-1:0] idx);
        access_req_t req;
        req.opcode      = op;
        req.comp_id     = comp;
        req.access_addr = addr;
        req.policy_word = pol;
        req.entry_index = idx;
        return req;
    endfunction

    function automatic directed_row_t dir_row(input logic [OPCODE_W-1:0] op,
                                              input logic [COMPID_W-1:0] comp,
                                              input logic [ADDR_W-1:0] addr,
                                              input logic [ADDR_W-1:0] pol,
                                              input logic [INDEX_W-1:0] idx,
                                              input bit typed,
                                              input status_t st,
                                              input logic [ADDR_W-1:0] lo,
                                              input logic [ADDR_W-1:0] hi,
                                              input logic [ADDR_W-1:0] sp);
        directed_row_t r;
        r.req   = make_req(op, comp, addr, pol, idx);
        r.typed = typed;
        r.rsp.status        = st;
        r.rsp.range_low     = lo;
        r.rsp.range_high    = hi;
        r.rsp.stored_policy = sp;
        return r;
    endfunction

    // Pick a record address: mostly next to or inside a known range, else fresh.
    function automatic logic [ADDR_W-1:0] record_address(input logic [COMPID_W-1:0] comp);
        int unsigned       k;
        int unsigned       pick;
        logic [ADDR_W-1:0] lo;
        logic [ADDR_W-1:0] hi;
        logic [ADDR_W-1:0] window;
        k = comp * RANGES_PER_COMPARTMENT + $urandom_range(0, 7);
        lo = tbl_start[k];
        hi = tbl_end[k];
        pick = $urandom_range(0, 99);
        window = $urandom_range(0, 1) ? REGION_A : REGION_B;
        if (lo != '0 && pick < 60) begin
            if (pick % 3 == 0)
                return lo - WORD_BYTES;
            else if (pick % 3 == 1)
                return hi;
            else
                return lo + $urandom_range(0, hi - lo);
        end else if (pick < 85) begin
            return window + WORD_BYTES * $urandom_range(0, WINDOW_WORDS - 1);
        end else if (pick < 92) begin
            return window + $urandom_range(0, 4 * WINDOW_WORDS - 1);
        end else if (pick < 96) begin
            case ($urandom_range(0, 4))
                0: return 32'h0000_0000;
                1: return 32'h0000_0004;
                2: return 32'hFFFF_FFFC;
                3: return 32'hFFFF_FFF8;
                default: return 32'hFFFF_FFFF;
            endcase
        end
        return $urandom();
    endfunction

    function automatic access_req_t random_request();
        access_req_t req;
        int unsigned pick;
        req = make_req(OP_RECORD, hot_comps[$urandom_range(0, 3)], $urandom(), $urandom(),
                       INDEX_W'($urandom_range(0, RANGES_PER_COMPARTMENT - 1)));
        pick = $urandom_range(0, 999);
        if (pick < 10) begin
            req.opcode  = $urandom_range(0, 1) ? OP_CLEAR : OP_CLEAR_ODD;
            req.comp_id = COMPID_W'($urandom_range(0, 255));
        end else if (pick < 60) begin
            req.opcode  = $urandom_range(0, 1) ? OP_READ : OP_RECORD;
            req.comp_id = COMPID_W'($urandom_range(NUM_COMPARTMENTS, 255));
        end else if (pick < 260) begin
            req.opcode = OP_READ;
            if ($urandom_range(0, 3) == 0)
                req.comp_id = COMPID_W'($urandom_range(0, NUM_COMPARTMENTS - 1));
            if ($urandom_range(0, 2) != 0)
                req.entry_index = INDEX_W'($urandom_range(0, 7));
        end else begin
            req.access_addr = record_address(req.comp_id);
        end
        return req;
    endfunction

    // Offer one transfer, wait for it to be taken, then queue its expected result.
    task automatic offer_request(input access_req_t req, input bit typed,
                                 input access_rsp_t typed_rsp);
        access_rsp_t predicted;
        if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_W - $bits(access_req_t)){1'b0}}, req};
        do @(posedge aclk); while (!s_tready);
        predicted = range_table_apply(req);
        pending_results.push_back(typed ? typed_rsp : predicted);
        if (req.opcode[OP_CLEAR_BIT])
            n_clears++;
        else if (req.comp_id >= NUM_COMPARTMENTS)
            n_bad_ids++;
        else if (req.opcode == OP_READ)
            n_reads++;
        else
            n_records++;
    endtask

    // Stop offering and wait until every queued result has come back.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
    endtask

    // Fill every slot of one compartment, then push past the end of its table.
    task automatic fill_compartment(input logic [COMPID_W-1:0] comp, output int sent);
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] stride;
        int n;
        base   = REGION_A + 16 * $urandom_range(0, 255);
        stride = 8 * $urandom_range(2, 4);
        offer_request(make_req(OP_CLEAR, comp, $urandom(), $urandom(), 0), 1'b0, '0);
        for (n = 0; n < RANGES_PER_COMPARTMENT; n++)
            offer_request(make_req(OP_RECORD, comp, base + stride * n, $urandom(),
                                   INDEX_W'($urandom_range(0, 127))), 1'b0, '0);
        offer_request(make_req(OP_RECORD, comp,
                               REGION_B + WORD_BYTES * $urandom_range(0, WINDOW_WORDS - 1),
                               $urandom(), 0), 1'b0, '0);
        offer_request(make_req(OP_RECORD, comp,
                               base + stride * $urandom_range(0, 127) + $urandom_range(0, 3),
                               $urandom(), 0), 1'b0, '0);
        offer_request(make_req(OP_RECORD, comp, base - WORD_BYTES, $urandom(), 0), 1'b0, '0);
        offer_request(make_req(OP_READ, comp, $urandom(), $urandom(),
                               INDEX_W'(RANGES_PER_COMPARTMENT - 1)), 1'b0, '0);
        sent = RANGES_PER_COMPARTMENT + 5;
    endtask

    // Result checker: every transfer on the result channel against the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            mon_got = m_tdata[$bits(access_rsp_t)-1:0];
            if (pending_results.size() == 0) begin
                if (mismatch_count < SHOWN_MISMATCHES)
                    $display("Unexpected result transfer: status %0d low %h high %h policy %h",
                             mon_got.status, mon_got.range_low, mon_got.range_high,
                             mon_got.stored_policy);
                mismatch_count++;
            end else begin
                mon_want = pending_results.pop_front();
                if (mon_got.status !== mon_want.status ||
                    mon_got.range_low !== mon_want.range_low ||
                    mon_got.range_high !== mon_want.range_high ||
                    mon_got.stored_policy !== mon_want.stored_policy) begin
                    if (mismatch_count < SHOWN_MISMATCHES) begin
                        $display("Mismatch on result %0d:", results_checked);
                        $display("  expected status %0d low %h high %h policy %h",
                                 mon_want.status, mon_want.range_low, mon_want.range_high,
                                 mon_want.stored_policy);
                        $display("  got      status %0d low %h high %h policy %h",
                                 mon_got.status, mon_got.range_low, mon_got.range_high,
                                 mon_got.stored_policy);
                    end
                    mismatch_count++;
                end
                results_by_status[mon_want.status]++;
                results_checked++;
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off when one is requested.
    initial begin
        forever begin
            @(posedge aclk);
            if (ready_holdoff != 0) begin
                m_tready <= 1'b0;
                repeat (ready_holdoff) @(posedge aclk);
                ready_holdoff = 0;
            end
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Watchdog on the total run length.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("Timed out after %0d cycles with %0d results outstanding.",
                     cycle_count, pending_results.size());
            $display("status: fail");
            $finish;
        end
    end

    // Stimulus: directed rows, then four phases of random traffic; phases 0 and 3 fill a compartment first.
    initial begin
        int r;
        int ph;
        int sent_in_phase;
        int burst;
        for (r = 0; r < 8; r++)
            results_by_status[r] = 0;

        // Reset state, extension at both ends, the covered case and the first empty slot.
        dir_rows.push_back(dir_row(OP_READ, 0, 0, 0, 0, 1, ST_READ, 0, 0, 0));
        dir_rows.push_back(dir_row(OP_RECORD, 0, 32'h1000, 32'hA5A5_A5A5, 0, 1, ST_NEW,
                                   32'h1000, 32'h1004, 32'hA5A5_A5A5));
        dir_rows.push_back(dir_row(OP_RECORD, 0, 32'h1004, 32'h5A5A_5A5A, 0, 1, ST_END,
                                   32'h1000, 32'h1008, 32'h5A5A_5A5A));
        dir_rows.push_back(dir_row(OP_RECORD, 0, 32'h0FFC, 32'h0000_0001, 0, 1, ST_START,
                                   32'h0FFC, 32'h1008, 32'h0000_0001));
        dir_rows.push_back(dir_row(OP_RECORD, 0, 32'h1002, 32'h8000_0000, 0, 1, ST_COVERED,
                                   32'h0FFC, 32'h1008, 32'h8000_0000));
        dir_rows.push_back(dir_row(OP_RECORD, 0, REGION_A, 32'hFFFF_FFFF, 0, 0, ST_NEW, 0, 0, 0));
        dir_rows.push_back(dir_row(OP_READ, 0, 32'hDEAD_BEEF, 32'hDEAD_BEEF, 1, 0,
                                   ST_READ, 0, 0, 0));
        // Wrap at the top of the address space, and a record of address zero.
        dir_rows.push_back(dir_row(OP_RECORD, 63, 32'hFFFF_FFFC, 32'hFFFF_FFFF, 7'h7F, 1, ST_NEW,
                                   32'hFFFF_FFFC, 32'h0000_0000, 32'hFFFF_FFFF));
        dir_rows.push_back(dir_row(OP_RECORD, 63, 0, 0, 0, 1, ST_NEW, 0, 32'h4, 0));
        dir_rows.push_back(dir_row(OP_RECORD, 63, 32'h40, 32'h1234_5678, 0, 0, ST_NEW, 0, 0, 0));
        dir_rows.push_back(dir_row(OP_READ, 63, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 0,
                                   ST_READ, 0, 0, 0));
        // Compartment ids out of range, then a read of the last slot of an unwritten compartment.
        dir_rows.push_back(dir_row(OP_RECORD, 64, 32'h1000, 1, 0, 1, ST_BAD_ID, 0, 0, 0));
        dir_rows.push_back(dir_row(OP_RECORD, 255, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 7'h7F, 1,
                                   ST_BAD_ID, 0, 0, 0));
        dir_rows.push_back(dir_row(OP_READ, 200, 0, 0, 7'h7F, 1, ST_BAD_ID, 0, 0, 0));
        dir_rows.push_back(dir_row(OP_READ, 5, 0, 0, 7'h7F, 1, ST_READ, 0, 0, 0));
        // A start extended down to zero leaves the slot empty again.
        dir_rows.push_back(dir_row(OP_RECORD, 5, 32'h8, 32'h0000_00FF, 0, 1, ST_NEW,
                                   32'h8, 32'hC, 32'h0000_00FF));
        dir_rows.push_back(dir_row(OP_RECORD, 5, 32'h4, 32'h0000_FF00, 0, 0, ST_NEW, 0, 0, 0));
        dir_rows.push_back(dir_row(OP_RECORD, 5, 32'h0, 32'h00FF_0000, 0, 0, ST_NEW, 0, 0, 0));
        dir_rows.push_back(dir_row(OP_READ, 5, 0, 0, 0, 0, ST_READ, 0, 0, 0));
        dir_rows.push_back(dir_row(OP_RECORD, 5, 32'h100, 32'hFF00_0000, 0, 0, ST_NEW, 0, 0, 0));
        dir_rows.push_back(dir_row(OP_RECORD, 0, 32'h0FF7, 32'h0F0F_0F0F, 0, 0, ST_NEW, 0, 0, 0));
        // Both clear opcodes, each followed by a read of cleared state.
        dir_rows.push_back(dir_row(OP_CLEAR, 17, 32'h1234, 32'h5678, 3, 1, ST_CLEARED, 0, 0, 0));
        dir_rows.push_back(dir_row(OP_READ, 0, 0, 0, 0, 1, ST_READ, 0, 0, 0));
        dir_rows.push_back(dir_row(OP_CLEAR_ODD, 200, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 7'h7F, 1,
                                   ST_CLEARED, 0, 0, 0));
        dir_rows.push_back(dir_row(OP_READ, 63, 0, 0, 1, 1, ST_READ, 0, 0, 0));

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i])
            offer_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].rsp);

        hot_comps[0] = 63;
        hot_comps[1] = 0;
        hot_comps[2] = COMPID_W'($urandom_range(1, 62));
        hot_comps[3] = COMPID_W'($urandom_range(1, 62));

        for (ph = 0; ph < 4; ph++) begin
            sent_in_phase = 0;
            send_idle_pct = (ph == 1) ? 73 : (ph == 3) ? 22 : 0;
            stall_pct     = (ph == 2) ? 73 : (ph == 3) ? 22 : 0;
            if (ph == 0) begin
                fill_compartment(hot_comps[0], burst);
                sent_in_phase += burst;
                // Let the block go idle, then hold the result side off while
                // transfers keep coming so that the input side backs up.
                drain_results();
                ready_holdoff = HOLDOFF_CYCLES;
            end else if (ph == 3) begin
                hot_comps[1] = COMPID_W'($urandom_range(0, NUM_COMPARTMENTS - 1));
                fill_compartment(hot_comps[1], burst);
                sent_in_phase += burst;
            end
            while (sent_in_phase < ITEMS_PER_PHASE) begin
                offer_request(random_request(), 1'b0, '0);
                sent_in_phase++;
            end
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d transfers: %0d records, %0d reads, %0d with a bad id, %0d clears.",
                 n_records + n_reads + n_bad_ids + n_clears, n_records, n_reads, n_bad_ids,
                 n_clears);
        $display("Checked %0d results: %0d new, %0d start, %0d end, %0d covered, %0d full,",
                 results_checked, results_by_status[ST_NEW], results_by_status[ST_START],
                 results_by_status[ST_END], results_by_status[ST_COVERED],
                 results_by_status[ST_FULL]);
        $display("  %0d bad id, %0d read, %0d cleared; %0d mismatches.",
                 results_by_status[ST_BAD_ID], results_by_status[ST_READ],
                 results_by_status[ST_CLEARED], mismatch_count);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
